// ----- sv/urtp_pkg.sv -----
`default_nettype none

package urtp_pkg;

    localparam int CP_W     = 21;
    localparam int STATUS_W = 2;
    localparam int RANGE_W  = 24;

    localparam int MAX_DIGITS_DEF  = 6;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [CP_W-1:0] MAX_CP     = 21'h10FFFF;
    localparam logic [CP_W-1:0] CHAR_PLUS  = 21'h00002B;
    localparam logic [CP_W-1:0] CHAR_QMARK = 21'h00003F;
    localparam logic [CP_W-1:0] CHAR_DASH  = 21'h00002D;
    localparam logic [3:0]      HEX_FILL   = 4'hF;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 2'd0,
        ST_MALFORMED    = 2'd1,
        ST_END_HIGH     = 2'd2,
        ST_START_AFTER  = 2'd3
    } t_status;

    // classified character handed from front to back
    typedef struct packed {
        logic       is_hex;
        logic [3:0] hex_val;
        logic       is_plus;
        logic       is_qmark;
        logic       is_dash;
        logic       last;
    } t_char_class;

endpackage

`default_nettype wire

// ----- sv/urtp_if.sv -----
`default_nettype none

interface urtp_in_if;
    logic                      valid;
    logic                      ready;
    logic [urtp_pkg::CP_W-1:0] code_point;
    logic                      last_char;

    modport source (output valid, output code_point, output last_char, input ready);
    modport sink   (input valid, input code_point, input last_char, output ready);
endinterface

interface urtp_out_if;
    logic                          valid;
    logic                          ready;
    logic [urtp_pkg::STATUS_W-1:0] status;
    logic [urtp_pkg::RANGE_W-1:0]  range_start;
    logic [urtp_pkg::RANGE_W-1:0]  range_end;

    modport source (output valid, output status, output range_start, output range_end,
                    input ready);
    modport sink   (input valid, input status, input range_start, input range_end,
                    output ready);
endinterface

`default_nettype wire

// ----- sv/unicode_range_token_parser_top.sv -----
`default_nettype none

// channel   dir  transaction              fields
// i_in      in   one range-text character code_point[20:0], last_char
// o_out     out  one parsed range         status[1:0], range_start[23:0], range_end[23:0]
//
// sustained rate is one character per cycle while the queue is not full
// o_out.valid is registered; the last character is first written into the queue,
// and the parser sets o_out.valid when it pops that character from the queue
// i_rst_n is synchronous; it empties the queue, idles the parser, drops o_out.valid
// the character queue (QUEUE_DEPTH entries) absorbs o_out stalls; i_in.ready
// falls only when the queue is full

module unicode_range_token_parser_top #(
    parameter int MAX_DIGITS  = urtp_pkg::MAX_DIGITS_DEF,
    parameter int QUEUE_DEPTH = urtp_pkg::QUEUE_DEPTH_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    urtp_in_if.sink    i_in,
    urtp_out_if.source o_out
);
    import urtp_pkg::*;

    // classified characters between front and back
    logic        q_push;
    logic        q_full;
    logic        q_valid;
    logic        q_pop;
    t_char_class q_wdata;
    t_char_class q_rdata;

    // front: input handshake and character classification
    urtp_front u_front (
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_data (q_wdata)
    );

    // short queue so each side can stall on its own
    urtp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata (q_wdata),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_rdata (q_rdata),
        .i_pop   (q_pop)
    );

    // back: parser state machine and registered result
    urtp_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_rdata),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire

// ----- sv/urtp_queue.sv -----
`default_nettype none

module urtp_queue #(
    parameter int DEPTH = urtp_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_push,
    input  wire urtp_pkg::t_char_class  i_wdata,
    output logic                        o_full,
    output logic                        o_valid,
    output urtp_pkg::t_char_class       o_rdata,
    input  wire                         i_pop
);
    import urtp_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_char_class        r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rdata = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- sv/urtp_front.sv -----
`default_nettype none

module urtp_front (
    urtp_in_if.sink               i_in,
    input  wire                   i_q_full,
    output logic                  o_q_push,
    output urtp_pkg::t_char_class o_q_data
);
    import urtp_pkg::*;

    logic [CP_W-1:0] cp;

    assign cp         = i_in.code_point;
    assign i_in.ready = !i_q_full;
    assign o_q_push   = i_in.valid && !i_q_full;

    always_comb begin
        o_q_data          = '0;
        o_q_data.last     = i_in.last_char;
        o_q_data.is_plus  = (cp == CHAR_PLUS);
        o_q_data.is_qmark = (cp == CHAR_QMARK);
        o_q_data.is_dash  = (cp == CHAR_DASH);
        if (cp inside {[21'h30 : 21'h39]}) begin
            o_q_data.is_hex  = 1'b1;
            o_q_data.hex_val = cp[3:0];
        end else if (cp inside {[21'h41 : 21'h46], [21'h61 : 21'h66]}) begin
            // letters a-f sit at low nibble 1..6
            o_q_data.is_hex  = 1'b1;
            o_q_data.hex_val = 4'(cp[3:0] + 4'd9);
        end
    end

endmodule

`default_nettype wire

// ----- sv/urtp_back.sv -----
`default_nettype none

module urtp_back #(
    parameter int MAX_DIGITS = urtp_pkg::MAX_DIGITS_DEF
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_q_valid,
    input  wire urtp_pkg::t_char_class i_q_data,
    output logic                       o_q_pop,
    urtp_out_if.source                 o_out
);
    import urtp_pkg::*;

    localparam int VAL_W = 4 * MAX_DIGITS;
    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int CMP_W = (VAL_W > RANGE_W) ? VAL_W : RANGE_W;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_FIRST,
        PH_WILD,
        PH_DASH,
        PH_SECOND
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [VAL_W-1:0]   r_first, n_first;
    logic [VAL_W-1:0]   r_second, n_second;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_err, n_err;

    logic               r_out_valid;
    t_status            r_status;
    logic [RANGE_W-1:0] r_start;
    logic [RANGE_W-1:0] r_end;

    logic               out_free;
    logic               count_full;
    logic               fin_err;
    logic [VAL_W-1:0]   fin_second;
    logic [CMP_W-1:0]   s_ext;
    logic [CMP_W-1:0]   e_ext;
    t_status            fin_status;

    assign out_free   = !r_out_valid || o_out.ready;
    assign o_q_pop    = i_q_valid && (!i_q_data.last || out_free);
    assign count_full = (r_count >= CNT_W'(MAX_DIGITS));

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_status;
    assign o_out.range_start = r_start;
    assign o_out.range_end   = r_end;

    // next parser state for one character
    always_comb begin
        n_phase  = r_phase;
        n_first  = r_first;
        n_second = r_second;
        n_count  = r_count;
        n_err    = r_err;
        if (!r_err) begin
            case (r_phase)
                PH_IDLE: begin
                    if (i_q_data.is_plus) begin
                        n_phase  = PH_FIRST;
                        n_first  = '0;
                        n_second = '0;
                        n_count  = '0;
                    end else begin
                        n_err = 1'b1;
                    end
                end
                PH_FIRST: begin
                    if (i_q_data.is_hex) begin
                        if (count_full) begin
                            n_err = 1'b1;
                        end else begin
                            n_count = r_count + CNT_W'(1);
                            n_first = VAL_W'(r_first << 4) | VAL_W'(i_q_data.hex_val);
                        end
                    end else if (i_q_data.is_qmark) begin
                        if (count_full) begin
                            n_err = 1'b1;
                        end else begin
                            n_count  = r_count + CNT_W'(1);
                            n_second = VAL_W'(r_first << 4) | VAL_W'(HEX_FILL);
                            n_first  = VAL_W'(r_first << 4);
                            n_phase  = PH_WILD;
                        end
                    end else if (i_q_data.is_dash) begin
                        if (r_count == '0) begin
                            n_err = 1'b1;
                        end else begin
                            n_phase  = PH_DASH;
                            n_count  = '0;
                            n_second = '0;
                        end
                    end else begin
                        n_err = 1'b1;
                    end
                end
                PH_WILD: begin
                    if (i_q_data.is_qmark && !count_full) begin
                        n_count  = r_count + CNT_W'(1);
                        n_first  = VAL_W'(r_first << 4);
                        n_second = VAL_W'(r_second << 4) | VAL_W'(HEX_FILL);
                    end else begin
                        n_err = 1'b1;
                    end
                end
                PH_DASH, PH_SECOND: begin
                    if (i_q_data.is_hex && !count_full) begin
                        n_count  = r_count + CNT_W'(1);
                        n_second = VAL_W'(r_second << 4) | VAL_W'(i_q_data.hex_val);
                        n_phase  = PH_SECOND;
                    end else begin
                        n_err = 1'b1;
                    end
                end
                default: n_err = 1'b1;
            endcase
        end
    end

    // end-of-text checks on the updated state
    always_comb begin
        fin_err    = n_err;
        fin_second = n_second;
        if (!n_err) begin
            if (n_phase == PH_FIRST && n_count != '0) begin
                fin_second = n_first;
            end else if (n_phase != PH_WILD && n_phase != PH_SECOND) begin
                fin_err = 1'b1;
            end
        end
        s_ext = CMP_W'(n_first);
        e_ext = CMP_W'(fin_second);
        if (fin_err) begin
            fin_status = ST_MALFORMED;
            s_ext      = '0;
            e_ext      = '0;
        end else if (e_ext > CMP_W'(MAX_CP)) begin
            fin_status = ST_END_HIGH;
        end else if (s_ext > e_ext) begin
            fin_status = ST_START_AFTER;
        end else begin
            fin_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_first     <= '0;
            r_second    <= '0;
            r_count     <= '0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_q_pop) begin
                if (i_q_data.last) begin
                    r_phase     <= PH_IDLE;
                    r_first     <= '0;
                    r_second    <= '0;
                    r_count     <= '0;
                    r_err       <= 1'b0;
                    r_out_valid <= 1'b1;
                    r_status    <= fin_status;
                    r_start     <= s_ext[RANGE_W-1:0];
                    r_end       <= e_ext[RANGE_W-1:0];
                end else begin
                    r_phase  <= n_phase;
                    r_first  <= n_first;
                    r_second <= n_second;
                    r_count  <= n_count;
                    r_err    <= n_err;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- sim/unicode_range_token_parser_top_test.sv -----
`default_nettype none

module unicode_range_token_parser_top_test;
    import urtp_pkg::*;

    localparam int DIGITS         = MAX_DIGITS_DEF;
    localparam int TOTAL_CHARS    = 750;
    localparam int CALM_CHARS     = 100;  // final stretch with no idling
    localparam int HOLD_CYCLES    = 48;   // long receiver hold-off
    localparam int PRESSURE_TEXTS = 14;
    localparam int TAIL_CYCLES    = 10;
    localparam int WATCHDOG_LIMIT = 500;

    // hex digit bounds
    localparam logic [CP_W-1:0] CH_0  = 21'h30;
    localparam logic [CP_W-1:0] CH_9  = 21'h39;
    localparam logic [CP_W-1:0] CH_UA = 21'h41;
    localparam logic [CP_W-1:0] CH_UF = 21'h46;
    localparam logic [CP_W-1:0] CH_LA = 21'h61;
    localparam logic [CP_W-1:0] CH_LF = 21'h66;

    // stand-ins used inside directed texts for code points a string cannot hold
    localparam byte MARK_TOP  = "~";  // stands for 0x10FFFF
    localparam byte MARK_ZERO = "^";  // stands for code point zero

    typedef enum logic [2:0] {
        PS_IDLE,
        PS_FIRST,
        PS_WILD,
        PS_DASH,
        PS_SECOND
    } t_scan_phase;

    typedef struct packed {
        t_status              status;
        logic [RANGE_W-1:0]   rstart;
        logic [RANGE_W-1:0]   rend;
    } t_range_res;

    typedef struct {
        string              text;
        bit                 typed;    // expected result written out below
        t_status            st;
        logic [RANGE_W-1:0] lo;
        logic [RANGE_W-1:0] hi;
    } t_directed_row;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    urtp_in_if  in_ch ();
    urtp_out_if out_ch ();

    unicode_range_token_parser_top #(
        .MAX_DIGITS(DIGITS)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    // parser shadow state
    t_scan_phase p_phase;
    logic [31:0] p_lo;
    logic [31:0] p_hi;
    int          p_ndig;
    bit          p_bad;

    t_range_res        pending_ranges[$];
    logic [CP_W-1:0]   chars_q[$];

    bit idle_on;
    bit hold_req;
    int n_errors;
    int n_chars;
    int n_texts;
    int n_ranges;
    int status_seen[4];
    int stall_cycles;

    // ------------------------------------------------------------------
    // range text predictor
    // ------------------------------------------------------------------

    function automatic void parser_clear();
        p_phase = PS_IDLE;
        p_lo    = '0;
        p_hi    = '0;
        p_ndig  = 0;
        p_bad   = 1'b0;
    endfunction

    function automatic int hex_digit(input logic [CP_W-1:0] c);
        if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
        if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
        if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
        return -1;
    endfunction

    // one more digit or wildcard; past the limit the text is malformed
    function automatic bit count_digit();
        if (p_ndig + 1 > DIGITS) begin
            p_bad = 1'b1;
            return 1'b0;
        end
        p_ndig++;
        return 1'b1;
    endfunction

    task automatic parser_take(input logic [CP_W-1:0] c, input logic last,
                               output bit done, output t_range_res res);
        int hv;
        hv   = hex_digit(c);
        done = 1'b0;
        res  = '0;
        // an error swallows everything up to the last character
        if (!p_bad) begin
            case (p_phase)
                PS_IDLE: begin
                    if (c == CHAR_PLUS) begin
                        p_phase = PS_FIRST;
                        p_lo    = '0;
                        p_hi    = '0;
                        p_ndig  = 0;
                    end else begin
                        p_bad = 1'b1;
                    end
                end
                PS_FIRST: begin
                    if (hv >= 0) begin
                        if (count_digit()) p_lo = (p_lo << 4) | hv[3:0];
                    end else if (c == CHAR_QMARK) begin
                        if (count_digit()) begin
                            p_hi    = (p_lo << 4) | HEX_FILL;
                            p_lo    = p_lo << 4;
                            p_phase = PS_WILD;
                        end
                    end else if (c == CHAR_DASH) begin
                        if (p_ndig == 0) begin
                            p_bad = 1'b1;
                        end else begin
                            p_phase = PS_DASH;
                            p_ndig  = 0;
                            p_hi    = '0;
                        end
                    end else begin
                        p_bad = 1'b1;
                    end
                end
                PS_WILD: begin
                    // only further wildcards may follow a wildcard
                    if (c == CHAR_QMARK) begin
                        if (count_digit()) begin
                            p_lo = p_lo << 4;
                            p_hi = (p_hi << 4) | HEX_FILL;
                        end
                    end else begin
                        p_bad = 1'b1;
                    end
                end
                PS_DASH, PS_SECOND: begin
                    if (hv >= 0) begin
                        if (count_digit()) begin
                            p_hi    = (p_hi << 4) | hv[3:0];
                            p_phase = PS_SECOND;
                        end
                    end else begin
                        p_bad = 1'b1;
                    end
                end
                default: p_bad = 1'b1;
            endcase
        end
        if (last) begin
            done = 1'b1;
            if (!p_bad) begin
                // a bare value is a one-point range
                if (p_phase == PS_FIRST && p_ndig != 0) p_hi = p_lo;
                else if (p_phase != PS_WILD && p_phase != PS_SECOND) p_bad = 1'b1;
            end
            if (p_bad) begin
                res.status = ST_MALFORMED;
            end else begin
                res.rstart = p_lo[RANGE_W-1:0];
                res.rend   = p_hi[RANGE_W-1:0];
                if (p_hi > MAX_CP) res.status = ST_END_HIGH;
                else if (p_lo > p_hi) res.status = ST_START_AFTER;
                else res.status = ST_OK;
            end
            parser_clear();
        end
    endtask

    // ------------------------------------------------------------------
    // character driver
    // ------------------------------------------------------------------

    // offers one character, returns at the edge where it was taken
    task automatic send_char(input logic [CP_W-1:0] c, input logic last,
                             input bit typed, input t_range_res typed_res);
        bit         done;
        t_range_res res;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.code_point <= c;
        in_ch.last_char  <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        n_chars++;
        parser_take(c, last, done, res);
        if (done) pending_ranges = {pending_ranges, (typed ? typed_res : res)};
    endtask

    task automatic send_text(input bit typed, input t_range_res typed_res);
        for (int i = 0; i < chars_q.size(); i++)
            send_char(chars_q[i], i == chars_q.size() - 1, typed, typed_res);
        n_texts++;
    endtask

    // appends one character to the text being built
    function automatic void add_char(input logic [CP_W-1:0] c);
        chars_q = {chars_q, c};
    endfunction

    function automatic void load_text(input string s);
        chars_q.delete();
        for (int i = 0; i < s.len(); i++) begin
            if (s[i] == MARK_TOP) add_char(MAX_CP);
            else if (s[i] == MARK_ZERO) add_char('0);
            else add_char({13'b0, s[i]});
        end
    endfunction

    // ------------------------------------------------------------------
    // random text builder
    // ------------------------------------------------------------------

    function automatic logic [CP_W-1:0] hex_char(input int v, input bit lower);
        if (v < 10) return CH_0 + CP_W'(v);
        return (lower ? CH_LA : CH_UA) + CP_W'(v - 10);
    endfunction

    // anything at all: full code point range or plain ascii
    function automatic logic [CP_W-1:0] noise_char();
        if ($urandom_range(0, 1) == 1) return CP_W'($urandom_range(0, int'(MAX_CP)));
        return CP_W'($urandom_range(0, 127));
    endfunction

    // mostly legal lengths, sometimes empty or one too many
    function automatic int digit_run_len();
        int r;
        r = $urandom_range(0, 24);
        if (r == 0) return 0;
        if (r == 1) return DIGITS + 1;
        return $urandom_range(1, DIGITS);
    endfunction

    task automatic make_random_text();
        int form;
        int n1;
        int n2;
        int nq;
        int pos;
        bit lower;
        chars_q.delete();
        form  = $urandom_range(0, 15);
        lower = 1'($urandom_range(0, 1));
        if (form == 0) begin
            // pure noise
            repeat ($urandom_range(1, 4)) add_char(noise_char());
        end else begin
            // form 1 leaves the plus sign out
            if (form != 1) add_char(CHAR_PLUS);
            n1 = digit_run_len();
            repeat (n1) add_char(hex_char($urandom_range(0, 15), lower));
            case ($urandom_range(0, 2))
                1: begin
                    nq = (n1 >= DIGITS) ? 1 : $urandom_range(1, DIGITS - n1);
                    if ($urandom_range(0, 9) == 0) nq++;
                    repeat (nq) add_char(CHAR_QMARK);
                end
                2: begin
                    add_char(CHAR_DASH);
                    n2 = digit_run_len();
                    repeat (n2) add_char(hex_char($urandom_range(0, 15), lower));
                end
                default: ;
            endcase
            if (chars_q.size() == 0) add_char(hex_char($urandom_range(0, 15), lower));
            // form 2 corrupts one character somewhere in the text
            if (form == 2) begin
                pos = $urandom_range(0, chars_q.size() - 1);
                chars_q[pos] = noise_char();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // result receiver: random stalls plus one long hold-off on request
    // ------------------------------------------------------------------

    initial begin
        int n;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                n = $urandom_range(1, 6);
                out_ch.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input logic [RANGE_W-1:0] want,
                               input logic [RANGE_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            n_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_range_res want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_ranges.size() == 0) begin
                $display("%0t: unexpected range transaction, expected none, actual %h %h %h",
                         $time, out_ch.status, out_ch.range_start, out_ch.range_end);
                n_errors++;
            end else begin
                want = pending_ranges.pop_front();
                check_field("status", RANGE_W'(want.status), RANGE_W'(out_ch.status));
                check_field("range_start", want.rstart, out_ch.range_start);
                check_field("range_end", want.rend, out_ch.range_end);
                n_ranges++;
                status_seen[out_ch.status]++;
            end
        end
    end

    // no transaction on either side for too long ends the run
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles == WATCHDOG_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("== FAIL ==");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    t_directed_row dir_rows[];

    initial begin
        t_range_res typed_res;
        in_ch.valid      <= 1'b0;
        in_ch.code_point <= '0;
        in_ch.last_char  <= 1'b0;
        idle_on          = 1'b1;
        hold_req         = 1'b0;
        n_errors         = 0;
        stall_cycles     = 0;
        parser_clear();

        // extremes, each special case, then a few checked only by the predictor
        dir_rows = '{
            '{"+0",             1, ST_OK,          24'h000000, 24'h000000},
            '{"+10FFFF",        1, ST_OK,          24'h10FFFF, 24'h10FFFF},
            '{"+110000",        1, ST_END_HIGH,    24'h110000, 24'h110000},
            '{"+1?",            1, ST_OK,          24'h000010, 24'h00001F},
            '{"+??????",        1, ST_END_HIGH,    24'h000000, 24'hFFFFFF},
            '{"+0-10FFFF",      1, ST_OK,          24'h000000, 24'h10FFFF},
            '{"+F-A",           1, ST_START_AFTER, 24'h00000F, 24'h00000A},
            '{"+a-f",           1, ST_OK,          24'h00000A, 24'h00000F},
            '{"+",              1, ST_MALFORMED,   24'h000000, 24'h000000},
            '{"+-5",            1, ST_MALFORMED,   24'h000000, 24'h000000},
            '{"+5-",            1, ST_MALFORMED,   24'h000000, 24'h000000},
            '{"+1234567",       1, ST_MALFORMED,   24'h000000, 24'h000000},
            '{"+123456?",       1, ST_MALFORMED,   24'h000000, 24'h000000},
            '{"+1?5",           1, ST_MALFORMED,   24'h000000, 24'h000000},
            '{"+1?-2",          1, ST_MALFORMED,   24'h000000, 24'h000000},
            '{"5",              1, ST_MALFORMED,   24'h000000, 24'h000000},
            '{"+~",             1, ST_MALFORMED,   24'h000000, 24'h000000},
            '{"+1^",            1, ST_MALFORMED,   24'h000000, 24'h000000},
            '{"+1x2",           1, ST_MALFORMED,   24'h000000, 24'h000000},
            '{"+9:",            1, ST_MALFORMED,   24'h000000, 24'h000000},
            '{"+g",             1, ST_MALFORMED,   24'h000000, 24'h000000},
            '{"+aBcD?",         0, ST_OK,          24'h000000, 24'h000000},
            '{"+10fffe-10FFFF", 0, ST_OK,          24'h000000, 24'h000000},
            '{"+Ab-9f",         0, ST_OK,          24'h000000, 24'h000000},
            '{"+0??",           0, ST_OK,          24'h000000, 24'h000000}
        };

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            load_text(dir_rows[r].text);
            typed_res.status = dir_rows[r].st;
            typed_res.rstart = dir_rows[r].lo;
            typed_res.rend   = dir_rows[r].hi;
            send_text(dir_rows[r].typed, typed_res);
        end

        // receiver holds off while short texts keep coming, so the queue fills
        idle_on  = 1'b0;
        hold_req = 1'b1;
        repeat (PRESSURE_TEXTS) begin
            load_text("+7");
            send_text(1'b0, typed_res);
        end
        // sender waits for every outstanding range
        in_ch.valid <= 1'b0;
        while (pending_ranges.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        // random texts, mostly well formed, the last stretch without idling
        while (n_chars < TOTAL_CHARS) begin
            idle_on = (n_chars < TOTAL_CHARS - CALM_CHARS) && ($urandom_range(0, 3) != 0);
            make_random_text();
            send_text(1'b0, typed_res);
        end
        in_ch.valid <= 1'b0;

        while (pending_ranges.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("sent %0d characters in %0d texts, one long hold-off, %0d ranges checked",
                 n_chars, n_texts, n_ranges);
        $display("status mix ok/malformed/end-high/start-after: %0d/%0d/%0d/%0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (n_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
